[src/chb_pkg.sv]
// Shared types and constants for the colour histogram binner.
// No dependencies; imported by every module of the block.
`default_nettype none
package chb_pkg;

  localparam int MaxBinsPerChannel = 8;
  localparam int MaxSamples        = 4096;
  localparam int ValueFracBits     = 16;
  localparam int ValueW            = ValueFracBits + 1;
  localparam int CountW            = 13;
  localparam int FreqFracBits      = 16;
  localparam int FreqW             = FreqFracBits + 1;
  localparam int BinIdxW           = 9;
  localparam int BinsRegW          = 4;
  localparam int CfgIdxW           = 2;
  localparam int ChanN             = 3;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } chb_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BINS_X = 2'd0,
    CFG_BINS_Y = 2'd1,
    CFG_BINS_Z = 2'd2
  } chb_cfg_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_LO, ST_HI, ST_SRCH, ST_CELL,
    ST_RMW, ST_RD, ST_DIV, ST_CLR, ST_FIN
  } chb_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic               in_image;
    logic [ValueW-1:0]  value_a;
    logic [ValueW-1:0]  value_b;
    logic [ValueW-1:0]  value_c;
    logic [1:0]         edge_channel;
    logic [3:0]         edge_slot;
    logic [ValueW-1:0]  edge_value;
    logic [BinIdxW-1:0] bin_index;
  } chb_in_t;

  typedef struct packed {
    logic               hit;
    logic [BinIdxW-1:0] hit_cell;
    logic [CountW-1:0]  cell_count;
    logic [FreqW-1:0]   frequency;
    logic [CountW-1:0]  samples_counted;
    logic               saturated;
  } chb_out_t;

  typedef struct packed {
    logic start;
    logic done;
  } chb_div_ctl_t;

endpackage
`default_nettype wire

[src/color_histogram_binner_unit.sv]
// Top level of the colour histogram binner: sequencer, edge tables, cell memory.
// Depends on chb_pkg and chb_div.
//
//  channel | direction | handshake           | word
//  in      | sink      | in_valid_i/in_stall_o   | chb_in_t
//  out     | source    | out_valid_o/out_stall_i | chb_out_t
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | index + 4-bit bin count
//
// One word at a time, taken only when idle. Sample: idle, edge-range checks (ST_LO,
// ST_HI), a binary search, cell index, read-modify-write, the divider (17-bit quotient,
// then done), result; outside the image it goes to the result, and in no bin or with
// MaxSamples counted it skips the read-modify-write and divider. Read bin: cell read,
// divider, result; the divider is skipped with nothing counted, and the read too for an
// index past the last cell. Load edge: idle, result. Clear: 512-cell sweep, result.
// After reset the same sweep zeroes all 512 cells before any word is taken; config
// writes are taken at all times. The result sits in an output register; a new word may
// be taken while it waits, but the next result holds until the previous one leaves.
`default_nettype none
module color_histogram_binner_unit import chb_pkg::*; #(
  parameter int MaxBins = MaxBinsPerChannel
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire chb_in_t            in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output chb_out_t                out_word_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [BinsRegW-1:0] cfg_data_i
);
  localparam int Slots = MaxBins + 1;
  localparam int SlotW = $clog2(Slots);
  localparam int Cells = MaxBins * MaxBins * MaxBins;
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  chb_state_e state_q, state_d;

  chb_in_t             item_q;
  logic [BinsRegW-1:0] bins_q [ChanN];
  logic [SlotW-1:0]    nb     [ChanN];
  logic [SlotW-1:0]    lo_q   [ChanN];
  logic [SlotW-1:0]    hi_q   [ChanN];
  logic [SlotW-1:0]    mid    [ChanN];
  logic [SlotW-1:0]    eaddr  [ChanN];
  logic [ValueW-1:0]   eval   [ChanN];
  logic [ValueW-1:0]   val    [ChanN];
  logic                miss_q [ChanN];
  logic                open_c [ChanN];
  logic [ValueW-1:0]   edge_q [ChanN][Slots];

  logic [CountW-1:0] total_q;
  logic              sat_q, hit_q;
  logic [AddrW-1:0]  cell_q, cell_c, clr_q, raddr, waddr;
  logic [CountW-1:0] count_q, wdata, rdata_q, inc;
  logic [FreqW-1:0]  freq_q, quot;
  logic              we, accept, fin_load, any_miss, srch_busy;
  logic              div_start;
  logic [CountW-1:0] div_num, div_den;
  chb_div_ctl_t      div_ctl;
  chb_out_t          out_q;
  logic              out_valid_q;

  logic [CountW-1:0] hist_mem [Cells];

  function automatic logic [SlotW-1:0] used_bins(input logic [BinsRegW-1:0] r);
    logic [SlotW-1:0] res;
    if (r == '0) res = SlotW'(1);
    else if (32'(r) > MaxBins) res = SlotW'(MaxBins);
    else res = SlotW'(r);
    return res;
  endfunction

  assign val[0] = item_q.value_a;
  assign val[1] = item_q.value_b;
  assign val[2] = item_q.value_c;

  // per-channel edge read: first edge, last edge, then the search midpoint
  always_comb begin
    for (int c = 0; c < ChanN; c++) begin
      nb[c]     = used_bins(bins_q[c]);
      mid[c]    = SlotW'(({1'b0, lo_q[c]} + {1'b0, hi_q[c]}) >> 1);
      open_c[c] = ({1'b0, lo_q[c]} + 1'b1) < {1'b0, hi_q[c]};
      case (state_q)
        ST_LO:   eaddr[c] = '0;
        ST_HI:   eaddr[c] = nb[c];
        default: eaddr[c] = mid[c];
      endcase
      eval[c] = edge_q[c][eaddr[c]];
    end
  end

  always_comb begin
    srch_busy = 1'b0;
    any_miss  = 1'b0;
    for (int c = 0; c < ChanN; c++) begin
      srch_busy = srch_busy | open_c[c];
      any_miss  = any_miss | miss_q[c];
    end
  end

  assign cell_c = AddrW'(32'(lo_q[0]) + 32'(lo_q[1]) * 32'(nb[0])
                  + 32'(lo_q[2]) * 32'(nb[0]) * 32'(nb[1]));
  assign inc    = rdata_q + 1'b1;

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (clr_q == AddrW'(Cells - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (chb_action_e'(in_word_i.action))
            ACT_SAMPLE: state_d = in_word_i.in_image ? ST_LO : ST_FIN;
            ACT_LOAD:   state_d = ST_FIN;
            ACT_READ:   state_d = (32'(in_word_i.bin_index) < Cells) ? ST_RD : ST_FIN;
            ACT_CLEAR:  state_d = ST_CLR;
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = ST_SRCH;
      ST_SRCH: if (!srch_busy) state_d = ST_CELL;
      ST_CELL: state_d = (any_miss || 32'(total_q) >= MaxSamples) ? ST_FIN : ST_RMW;
      ST_RMW:  state_d = ST_DIV;
      ST_RD:   state_d = (total_q == '0) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_ctl.done) state_d = ST_FIN;
      ST_CLR:  if (clr_q == AddrW'(Cells - 1)) state_d = ST_FIN;
      ST_FIN:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && !in_stall_o;
    fin_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
    we         = 1'b0;
    waddr      = cell_q;
    wdata      = inc;
    raddr      = AddrW'(in_word_i.bin_index);
    div_start  = 1'b0;
    div_num    = rdata_q;
    div_den    = total_q;
    unique case (state_q)
      ST_INIT, ST_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      ST_CELL: raddr = cell_c;
      ST_RMW: begin
        we        = 1'b1;
        div_start = 1'b1;
        div_num   = inc;
        div_den   = total_q + 1'b1;
      end
      ST_RD:   div_start = (total_q != '0);
      default: ;
    endcase
  end

  // ---- cell memory ----
  always_ff @(posedge clk_i) begin
    if (we) hist_mem[waddr] <= wdata;
    rdata_q <= hist_mem[raddr];
  end

  // ---- edge tables (undefined until loaded) ----
  always_ff @(posedge clk_i) begin
    if (accept && chb_action_e'(in_word_i.action) == ACT_LOAD &&
        in_word_i.edge_channel < 2'(ChanN) && 32'(in_word_i.edge_slot) < Slots) begin
      edge_q[in_word_i.edge_channel][SlotW'(in_word_i.edge_slot)] <= in_word_i.edge_value;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < ChanN; c++) bins_q[c] <= BinsRegW'(8);
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (chb_cfg_e'(cfg_index_i))
          CFG_BINS_X: bins_q[0] <= cfg_data_i;
          CFG_BINS_Y: bins_q[1] <= cfg_data_i;
          CFG_BINS_Z: bins_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_INIT || state_q == ST_CLR) clr_q <= clr_q + 1'b1;
      else clr_q <= '0;
      if (accept && chb_action_e'(in_word_i.action) == ACT_CLEAR) begin
        total_q <= '0;
        sat_q   <= 1'b0;
      end
      if (state_q == ST_CELL && !any_miss && 32'(total_q) >= MaxSamples) sat_q <= 1'b1;
      if (state_q == ST_RMW) total_q <= total_q + 1'b1;
      if (fin_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_word_i;
      hit_q   <= 1'b0;
      count_q <= '0;
      freq_q  <= '0;
    end
    unique case (state_q)
      ST_LO: for (int c = 0; c < ChanN; c++) miss_q[c] <= val[c] < eval[c];
      ST_HI: begin
        for (int c = 0; c < ChanN; c++) begin
          miss_q[c] <= miss_q[c] | (val[c] > eval[c]);
          lo_q[c]   <= '0;
          hi_q[c]   <= nb[c];
        end
      end
      ST_SRCH: begin
        for (int c = 0; c < ChanN; c++) begin
          if (open_c[c]) begin
            if (val[c] >= eval[c]) lo_q[c] <= mid[c];
            else hi_q[c] <= mid[c];
          end
        end
      end
      ST_CELL: cell_q <= cell_c;
      ST_RMW: begin
        hit_q   <= 1'b1;
        count_q <= inc;
      end
      ST_RD:  count_q <= rdata_q;
      ST_DIV: if (div_ctl.done) freq_q <= quot;
      default: ;
    endcase
    if (fin_load) begin
      out_q.hit             <= hit_q;
      out_q.hit_cell        <= hit_q ? BinIdxW'(cell_q) : '0;
      out_q.cell_count      <= count_q;
      out_q.frequency       <= freq_q;
      out_q.samples_counted <= total_q;
      out_q.saturated       <= sat_q;
    end
  end

  chb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .ctl_o  (div_ctl),
    .quot_o (quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;
endmodule
`default_nettype wire

[src/chb_div.sv]
// Restoring divider: (num << 16) / den for num <= den, one quotient bit a cycle.
// Depends on chb_pkg.
`default_nettype none
module chb_div import chb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CountW-1:0] num_i,
  input  wire logic [CountW-1:0] den_i,
  output chb_div_ctl_t           ctl_o,
  output logic [FreqW-1:0]       quot_o
);
  localparam int StepW = $clog2(FreqW);

  logic              run_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [CountW:0]   rem_q, trial;
  logic [CountW-1:0] den_q;
  logic [FreqW-1:0]  quot_q;

  // first step compares without a shift (integer bit of the quotient)
  assign trial = (step_q == '0) ? rem_q : {rem_q[CountW-1:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(FreqW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q  <= trial - {1'b0, den_q};
        quot_q <= {quot_q[FreqW-2:0], 1'b1};
      end else begin
        rem_q  <= trial;
        quot_q <= {quot_q[FreqW-2:0], 1'b0};
      end
    end
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign quot_o      = quot_q;
endmodule
`default_nettype wire

[src/chb_checker.sv]
// Port-level checks for the colour histogram binner, bound to its top level.
// Depends on chb_pkg.
`default_nettype none
module chb_checker import chb_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire chb_out_t out_word_o
);
  a_in_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.hit |->
      out_word_o.cell_count != '0 && out_word_o.frequency != '0)
    else $error("hit word with empty count or frequency");

  a_miss_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.hit |-> out_word_o.hit_cell == '0)
    else $error("cell index on a word without hit");

  a_count_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.cell_count <= out_word_o.samples_counted)
    else $error("cell count above sample total");
endmodule

bind color_histogram_binner_unit chb_checker u_chb_checker (.*);
`default_nettype wire
